FILE: rtl/circular_deque_top_macros.svh
// Assertion macros for the circular deque block.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef CIRCULAR_DEQUE_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CDQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");
`define CDQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");
`else
`define CDQ_ASSERT_IMP(label, ante, cons)
`define CDQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: rtl/cdq_pkg.sv
// Shared types and codes for the circular deque block.
// No dependencies.
package cdq_pkg;

	localparam int WORD_W = 32;
	localparam int OP_W = 3;
	localparam int STAT_W = 2;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_TUSER_W = 8;
	localparam int IN_TUSER_W = 8;

	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_REM_REAR  = 3'd3;
	localparam logic [OP_W-1:0] OP_NOP       = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

	localparam logic signed [WORD_W-1:0] NEG_ONE = -32'sd1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FILL,
		S_SEND
	} cdq_state_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] removed_value;
		logic [STAT_W-1:0]        status;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] rear_value;
		logic                     is_empty;
		logic                     is_full;
	} cdq_result_t;

endpackage

FILE: rtl/circular_deque_top.sv
// Circular deque of DEPTH signed words: one operation request in, one result out.
// Result: registered in the send state after accept; a removal that leaves words first
// passes a fill state that refills the end-word cache from the one-read-port word store.
// Requests are taken only when no result is pending, so one is in flight at a time.
// Reset (arst_n low, asynchronous): queue empty, pointers zero, no result pending, store
// not cleared. Depends on cdq_pkg, cdq_ctrl, cdq_ram and circular_deque_top_macros.svh.
`include "circular_deque_top_macros.svh"

module circular_deque_top
	import cdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request channel
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [31:0] data_in
	input  logic [IN_TUSER_W-1:0]  s_tuser,  // [2:0] op, upper bits unused
	// result channel
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [31:0] removed_value, [63:32] front_value, [95:64] rear_value,
	// [96] is_empty, [97] is_full, [103:98] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [OUT_TUSER_W-1:0] m_tuser   // [1:0] status, upper bits zero
);

	localparam int AW = $clog2(DEPTH);

	cdq_result_t res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;

	// Pointer and sequencing logic; holds cached front and rear words
	cdq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser[OP_W-1:0]),
		.in_data   (s_tdata[WORD_W-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Word store: inserts write here, removals read the new end word back
	cdq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Pack the result fields, lowest field first, zero fill to whole bytes
	assign m_tdata = {6'b0, res.is_full, res.is_empty,
		res.rear_value, res.front_value, res.removed_value};
	assign m_tuser = {(OUT_TUSER_W - STAT_W)'(0), res.status};

	// One request in flight at a time: never ready while a result waits
	`CDQ_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
	// An accepted request always blocks the input on the next cycle
	`CDQ_ASSERT_NXT(a_accept_blocks, s_tvalid && s_tready, !s_tready)
	// A refused insert only happens on a full queue
	`CDQ_ASSERT_IMP(a_ovf_full, m_tvalid && (res.status == STAT_OVERFLOW), res.is_full)
	// Underflow leaves the queue empty, and empty is never full
	`CDQ_ASSERT_IMP(a_udf_empty, m_tvalid && (res.status == STAT_UNDERFLOW),
		res.is_empty && !res.is_full)

endmodule

FILE: rtl/cdq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/cdq_ctrl.sv
// Deque control: head/tail pointers, cached end words, operation sequencer.
// Depends on cdq_pkg; drives the word store held in cdq_ram.
module cdq_ctrl
	import cdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          in_op,
	input  logic signed [WORD_W-1:0] in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output cdq_result_t              res,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic [WORD_W-1:0]        mem_wdata,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	input  logic [WORD_W-1:0]        mem_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	cdq_state_t state_q, state_d;
	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic empty_q, empty_d;
	logic full;
	logic signed [WORD_W-1:0] front_q, rear_q, front_d, rear_d;
	logic signed [WORD_W-1:0] removed_q, removed_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic rd_front_q, rd_front_d;
	logic rd_need, wr_need;
	logic acc;

	assign acc  = in_valid && in_ready;
	assign full = !empty_q && (head_q == wrap_inc(tail_q));

	// Operation decode and pointer update
	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		empty_d    = empty_q;
		front_d    = front_q;
		rear_d     = rear_q;
		removed_d  = NEG_ONE;
		status_d   = STAT_OK;
		wr_need    = 1'b0;
		rd_need    = 1'b0;
		rd_front_d = 1'b1;
		mem_waddr  = head_q;
		mem_raddr  = head_q;
		unique case (in_op) inside
			OP_INS_FRONT, OP_INS_REAR: begin
				if (full) begin
					status_d = STAT_OVERFLOW;
				end else if (empty_q) begin
					head_d    = '0;
					tail_d    = '0;
					empty_d   = 1'b0;
					wr_need   = 1'b1;
					mem_waddr = '0;
					front_d   = in_data;
					rear_d    = in_data;
				end else if (in_op == OP_INS_FRONT) begin
					head_d    = wrap_dec(head_q);
					wr_need   = 1'b1;
					mem_waddr = head_d;
					front_d   = in_data;
				end else begin
					tail_d    = wrap_inc(tail_q);
					wr_need   = 1'b1;
					mem_waddr = tail_d;
					rear_d    = in_data;
				end
			end
			OP_REM_FRONT, OP_REM_REAR: begin
				if (empty_q) begin
					status_d = STAT_UNDERFLOW;
				end else if (head_q == tail_q) begin
					// last word leaves: front and rear cache hold the same word
					removed_d = front_q;
					head_d    = '0;
					tail_d    = '0;
					empty_d   = 1'b1;
				end else if (in_op == OP_REM_FRONT) begin
					removed_d  = front_q;
					head_d     = wrap_inc(head_q);
					mem_raddr  = head_d;
					rd_need    = 1'b1;
					rd_front_d = 1'b1;
				end else begin
					removed_d  = rear_q;
					tail_d     = wrap_dec(tail_q);
					mem_raddr  = tail_d;
					rd_need    = 1'b1;
					rd_front_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_we    = acc && wr_need;
	assign mem_wdata = in_data;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					state_d = rd_need ? S_FILL : S_SEND;
				end
			end
			S_FILL: begin
				state_d = S_SEND;
			end
			S_SEND: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_SEND: out_valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (acc) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				empty_q <= empty_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			front_q    <= front_d;
			rear_q     <= rear_d;
			removed_q  <= removed_d;
			status_q   <= status_d;
			rd_front_q <= rd_front_d;
		end else if (state_q == S_FILL) begin
			if (rd_front_q) begin
				front_q <= mem_rdata;
			end else begin
				rear_q <= mem_rdata;
			end
		end
	end

	assign res.removed_value = removed_q;
	assign res.status        = status_q;
	assign res.front_value   = empty_q ? NEG_ONE : front_q;
	assign res.rear_value    = empty_q ? NEG_ONE : rear_q;
	assign res.is_empty      = empty_q;
	assign res.is_full       = full;

endmodule
